// ===== rtl/grid_run_slot_extractor_assert.svh =====
// Assertion helpers for the run extractor. Both expect clk and arst_n in scope.
`ifndef GRID_RUN_SLOT_EXTRACTOR_ASSERT_SVH
`define GRID_RUN_SLOT_EXTRACTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define GRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GRS_ASSERT_IMP(lbl, ante, cons, msg)
`define GRS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/grs_pkg.sv =====
`default_nettype none
package grs_pkg;

	localparam int MAX_DIM   = 32;
	localparam int DIM_W     = 6;
	localparam int POS_W     = 5;
	localparam int CNT_W     = 10;
	localparam int MASK_W    = 33;
	localparam int CFG_IDX_W = 1;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;
	localparam int Q_CNT_W   = 3;

	typedef enum logic [1:0] {
		KIND_ACROSS = 2'd0,
		KIND_DOWN   = 2'd1,
		KIND_SUM    = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS = 1'b0,
		CFG_COLS = 1'b1
	} cfg_idx_t;

	// everything one cell produces, queued as one word
	typedef struct packed {
		logic              h_vld;
		logic [DIM_W-1:0]  h_len;
		logic [POS_W-1:0]  h_row;
		logic [POS_W-1:0]  h_sc;
		logic [POS_W-1:0]  h_ec;
		logic              v_vld;
		logic [DIM_W-1:0]  v_len;
		logic [POS_W-1:0]  v_sr;
		logic [POS_W-1:0]  v_er;
		logic [POS_W-1:0]  v_col;
		logic              s_vld;
		logic [CNT_W-1:0]  s_across;
		logic [CNT_W-1:0]  s_down;
		logic [MASK_W-1:0] s_mask;
	} entry_t;

	typedef struct packed {
		logic               vld;
		logic               full;
		logic [Q_CNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [DIM_W-1:0]  run_length;
		logic [POS_W-1:0]  first_row;
		logic [POS_W-1:0]  first_col;
		logic [POS_W-1:0]  end_row;
		logic [POS_W-1:0]  end_col;
		logic [CNT_W-1:0]  across_total;
		logic [CNT_W-1:0]  down_total;
		logic [MASK_W-1:0] lengths_seen;
		logic              last;
	} res_t;

	// 0 acts as 1, anything above MAX_DIM as MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/grid_run_slot_extractor.sv =====
// Binary grid run extractor.
// Cells come in row-major order on the cell channel (cell_valid, cell_stall,
// is_black), one word per cell. White runs of two or more cells, across and
// down, leave on the result channel (res_valid, res_stall and the payload),
// one word per run; the grid's last cell adds a summary word with both run
// counts and the length bitmap. last marks the final word of each cell.
// Grid size is set on the cfg port (index 0 rows, index 1 columns); cfg_ready
// is always high, and writes belong between grids while the block is idle.
// Throughput: one cell per cycle while each cell yields at most one word and
// res_stall is low; the result port moves one word per cycle, so a cell with
// two or three words sends them one after another. A four-entry queue between
// the cell tracker and the output serializer absorbs bursts. A cell's words
// are written into the queue and then into the registered result word before
// res_valid shows them. When the receiver stalls the result word holds, the
// queue fills and then cell_stall rises. Reset clears positions, runs, counts
// and the queue and sets both dimensions to 32; no clearing pass is needed.
`default_nettype none
`include "grid_run_slot_extractor_assert.svh"
module grid_run_slot_extractor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [grs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [grs_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          cell_valid,
	output logic                          cell_stall,
	input  logic                          is_black,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [1:0]                    kind,
	output logic [grs_pkg::DIM_W-1:0]     run_length,
	output logic [grs_pkg::POS_W-1:0]     first_row,
	output logic [grs_pkg::POS_W-1:0]     first_col,
	output logic [grs_pkg::POS_W-1:0]     end_row,
	output logic [grs_pkg::POS_W-1:0]     end_col,
	output logic [grs_pkg::CNT_W-1:0]     across_total,
	output logic [grs_pkg::CNT_W-1:0]     down_total,
	output logic [grs_pkg::MASK_W-1:0]    lengths_seen,
	output logic                          last
);
	import grs_pkg::*;

	logic    cell_take, push, pop;
	entry_t  push_entry, head;
	q_stat_t q_stat;
	res_t    res;

	assign cfg_ready  = 1'b1;
	assign cell_stall = q_stat.full;
	assign cell_take  = cell_valid && !cell_stall;

	grs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_take  (cell_take),
		.is_black   (is_black),
		.push       (push),
		.push_entry (push_entry)
	);

	grs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	grs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

	assign kind         = res.kind;
	assign run_length   = res.run_length;
	assign first_row    = res.first_row;
	assign first_col    = res.first_col;
	assign end_row      = res.end_row;
	assign end_col      = res.end_col;
	assign across_total = res.across_total;
	assign down_total   = res.down_total;
	assign lengths_seen = res.lengths_seen;
	assign last         = res.last;

	`GRS_ASSERT_IMP(a_sum_is_last, res_valid && res.kind == KIND_SUM, res.last, "summary not last")
	`GRS_ASSERT_IMP(a_q_bound, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH), "queue overrun")
	`GRS_ASSERT_NXT(a_no_phantom, !q_stat.vld && !res_valid, !res_valid, "word from empty queue")

endmodule
`default_nettype wire

// ===== rtl/grs_front.sv =====
`default_nettype none
module grs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [grs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [grs_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          cell_take,
	input  logic                          is_black,
	output logic                          push,
	output grs_pkg::entry_t               push_entry
);
	import grs_pkg::*;

	logic [DIM_W-1:0]  rows_q, cols_q;
	logic [POS_W-1:0]  row_pos_q, col_pos_q;
	logic [DIM_W-1:0]  across_len_q;
	logic [POS_W-1:0]  across_start_q;
	logic [DIM_W-1:0]  down_len_q [MAX_DIM];
	logic [POS_W-1:0]  down_start_q [MAX_DIM];
	logic [CNT_W-1:0]  across_count_q, down_count_q;
	logic [MASK_W-1:0] mask_q;

	logic [DIM_W-1:0]  rows_eff, cols_eff;
	logic              last_col, last_row, grid_end;
	logic [DIM_W-1:0]  a_inc, a_len_n, d_len, d_inc, d_len_n;
	logic [POS_W-1:0]  a_start_n, d_start, d_start_n;
	logic [CNT_W-1:0]  across_n, down_n;
	logic [MASK_W-1:0] mask_n;
	entry_t            e;

	assign rows_eff = eff_dim(rows_q);
	assign cols_eff = eff_dim(cols_q);
	assign last_col = ({1'b0, col_pos_q} + DIM_W'(1)) >= cols_eff;
	assign last_row = ({1'b0, row_pos_q} + DIM_W'(1)) >= rows_eff;
	assign grid_end = last_col && last_row;
	assign d_len    = down_len_q[col_pos_q];
	assign d_start  = down_start_q[col_pos_q];
	assign a_inc    = across_len_q + DIM_W'(1);
	assign d_inc    = d_len + DIM_W'(1);

	always_comb begin
		e         = '0;
		a_len_n   = across_len_q;
		a_start_n = across_start_q;
		d_len_n   = d_len;
		d_start_n = d_start;

		// across
		e.h_row = row_pos_q;
		if (is_black) begin
			e.h_vld = across_len_q > DIM_W'(1);
			e.h_len = across_len_q;
			e.h_sc  = across_start_q;
			e.h_ec  = col_pos_q - POS_W'(1);
			a_len_n = '0;
		end else begin
			a_start_n = (across_len_q == '0) ? col_pos_q : across_start_q;
			e.h_len   = a_inc;
			e.h_sc    = a_start_n;
			e.h_ec    = col_pos_q;
			if (last_col) begin
				e.h_vld = a_inc > DIM_W'(1);
				a_len_n = '0;
			end else begin
				a_len_n = a_inc;
			end
		end

		// down, this column
		e.v_col = col_pos_q;
		if (is_black) begin
			e.v_vld = d_len > DIM_W'(1);
			e.v_len = d_len;
			e.v_sr  = d_start;
			e.v_er  = row_pos_q - POS_W'(1);
			d_len_n = '0;
		end else begin
			d_start_n = (d_len == '0) ? row_pos_q : d_start;
			e.v_len   = d_inc;
			e.v_sr    = d_start_n;
			e.v_er    = row_pos_q;
			if (last_row) begin
				e.v_vld = d_inc > DIM_W'(1);
				d_len_n = '0;
			end else begin
				d_len_n = d_inc;
			end
		end

		across_n = across_count_q + CNT_W'(e.h_vld);
		down_n   = down_count_q + CNT_W'(e.v_vld);
		mask_n   = mask_q
			| (e.h_vld ? (MASK_W'(1) << e.h_len) : '0)
			| (e.v_vld ? (MASK_W'(1) << e.v_len) : '0);

		e.s_vld    = grid_end;
		e.s_across = across_n;
		e.s_down   = down_n;
		e.s_mask   = mask_n;
	end

	assign push       = cell_take && (e.h_vld || e.v_vld || e.s_vld);
	assign push_entry = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q         <= DIM_W'(MAX_DIM);
			cols_q         <= DIM_W'(MAX_DIM);
			row_pos_q      <= '0;
			col_pos_q      <= '0;
			across_len_q   <= '0;
			across_start_q <= '0;
			across_count_q <= '0;
			down_count_q   <= '0;
			mask_q         <= '0;
			for (int i = 0; i < MAX_DIM; i++) begin
				down_len_q[i]   <= '0;
				down_start_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ROWS: rows_q <= cfg_data;
					CFG_COLS: cols_q <= cfg_data;
					default:  ;
				endcase
			end
			if (cell_take) begin
				if (grid_end) begin
					row_pos_q      <= '0;
					col_pos_q      <= '0;
					across_len_q   <= '0;
					across_start_q <= '0;
					across_count_q <= '0;
					down_count_q   <= '0;
					mask_q         <= '0;
					for (int i = 0; i < MAX_DIM; i++) begin
						down_len_q[i]   <= '0;
						down_start_q[i] <= '0;
					end
				end else begin
					across_len_q            <= a_len_n;
					across_start_q          <= a_start_n;
					down_len_q[col_pos_q]   <= d_len_n;
					down_start_q[col_pos_q] <= d_start_n;
					across_count_q          <= across_n;
					down_count_q            <= down_n;
					mask_q                  <= mask_n;
					if (last_col) begin
						col_pos_q <= '0;
						row_pos_q <= row_pos_q + POS_W'(1);
					end else begin
						col_pos_q <= col_pos_q + POS_W'(1);
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/grs_queue.sv =====
`default_nettype none
module grs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  grs_pkg::entry_t  push_entry,
	input  logic             pop,
	output grs_pkg::entry_t  head,
	output grs_pkg::q_stat_t stat
);
	import grs_pkg::*;

	entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push, do_pop;

	assign stat.vld   = count_q != '0;
	assign stat.full  = count_q == Q_CNT_W'(Q_DEPTH);
	assign stat.count = count_q;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.vld;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/grs_back.sv =====
`default_nettype none
module grs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  grs_pkg::entry_t  head,
	input  grs_pkg::q_stat_t q_stat,
	output logic             pop,
	input  logic             res_stall,
	output logic             res_valid,
	output grs_pkg::res_t    res
);
	import grs_pkg::*;

	logic [2:0] sent_q;
	logic       res_valid_q;
	res_t       res_q;

	logic [2:0] pend, pick;
	logic       rest, load;
	res_t       sel;

	assign pend = {head.s_vld, head.v_vld, head.h_vld} & ~sent_q;
	assign load = q_stat.vld && (!res_valid_q || !res_stall);

	// one result a cycle while res_stall is low: across first, then down, then summary
	always_comb begin
		sel  = '0;
		pick = '0;
		rest = 1'b0;
		if (pend[0]) begin
			pick           = 3'b001;
			rest           = pend[2:1] != '0;
			sel.kind       = KIND_ACROSS;
			sel.run_length = head.h_len;
			sel.first_row  = head.h_row;
			sel.first_col  = head.h_sc;
			sel.end_row    = head.h_row;
			sel.end_col    = head.h_ec;
		end else if (pend[1]) begin
			pick           = 3'b010;
			rest           = pend[2];
			sel.kind       = KIND_DOWN;
			sel.run_length = head.v_len;
			sel.first_row  = head.v_sr;
			sel.first_col  = head.v_col;
			sel.end_row    = head.v_er;
			sel.end_col    = head.v_col;
		end else begin
			pick             = 3'b100;
			sel.kind         = KIND_SUM;
			sel.across_total = head.s_across;
			sel.down_total   = head.s_down;
			sel.lengths_seen = head.s_mask;
		end
		sel.last = !rest;
	end

	assign pop       = load && !rest;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			sent_q      <= '0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				sent_q      <= rest ? (sent_q | pick) : '0;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
